@@ rtl/core/fpda_pkg.sv @@
// Shared types, constants and the power-of-ten table for the decimal ASCII converter.
`default_nettype none

package fpda_pkg;

  // Fixed field widths of the beats
  localparam int unsigned VALUE_W = 50;
  localparam int unsigned PREC_W  = 5;
  localparam int unsigned CHAR_W  = 8;

  // Defaults for the top-level parameters
  localparam int unsigned FRAC_BITS_DEF  = 32;
  localparam int unsigned MAX_DIGITS_DEF = 15;

  // Integer part after the range check never exceeds 100000
  localparam int unsigned RANGE_LIMIT = 100000;
  localparam int unsigned IP_W        = 17;
  localparam int unsigned EXP_W       = 3;
  localparam int unsigned DIG_W       = 4;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_QUERY = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

  // Input beat
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [PREC_W-1:0]         precision;
  } in_t;

  // Output beat
  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_of_run;
    logic              rejected;
  } out_t;

  // Power of ten for an integer place, units to ten-thousands
  function automatic logic [IP_W-1:0] pow10(input logic [EXP_W-1:0] e);
    logic [IP_W-1:0] p;
    unique case (e)
      3'd0:    p = IP_W'(1);
      3'd1:    p = IP_W'(10);
      3'd2:    p = IP_W'(100);
      3'd3:    p = IP_W'(1000);
      3'd4:    p = IP_W'(10000);
      default: p = IP_W'(10000);
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/fpda_digit_unit.sv @@
// Shared digit arithmetic: compare-and-subtract for integer places, times ten for fraction places.
`default_nettype none

module fpda_digit_unit #(
  parameter int unsigned FRAC_BITS = fpda_pkg::FRAC_BITS_DEF
) (
  input  wire logic [fpda_pkg::IP_W-1:0]   ip_i,
  input  wire logic [fpda_pkg::IP_W-1:0]   pow_i,
  input  wire logic [FRAC_BITS-1:0]        fr_i,
  output logic                             ge_o,
  output logic [fpda_pkg::IP_W-1:0]        ip_diff_o,
  output logic [fpda_pkg::DIG_W-1:0]       fdig_o,
  output logic [FRAC_BITS-1:0]             fr_next_o
);

  localparam int unsigned PROD_W = FRAC_BITS + fpda_pkg::DIG_W;

  logic [fpda_pkg::IP_W:0] diff;
  logic [PROD_W-1:0]       prod;

  // One subtract step; the borrow tells whether the place value still fits
  assign diff      = {1'b0, ip_i} - {1'b0, pow_i};
  assign ge_o      = ~diff[fpda_pkg::IP_W];
  assign ip_diff_o = diff[fpda_pkg::IP_W-1:0];

  // fraction * 10 as (fr << 3) + (fr << 1); the carry-out is the next digit
  assign prod      = {1'b0, fr_i, 3'b000} + {3'b000, fr_i, 1'b0};
  assign fdig_o    = prod[PROD_W-1:FRAC_BITS];
  assign fr_next_o = prod[FRAC_BITS-1:0];

endmodule

`default_nettype wire

@@ rtl/core/fixed_point_to_decimal_ascii.sv @@
// Top level: signed Q.FRAC_BITS number to an ASCII decimal byte run, one byte per beat.
// Flow: an accepted item is checked first, then bytes go out one per cycle while the
//   output is not stalled; each integer digit is first found by repeated subtraction.
// Items: one item at a time, up to 19 bytes per item; the shared compare-and-subtract
//   unit sets the integer digit time.
// Reset: asynchronous, active low; the sequencer returns to idle and the output empties.
`default_nettype none

module fixed_point_to_decimal_ascii #(
  parameter int unsigned FRAC_BITS  = fpda_pkg::FRAC_BITS_DEF,
  parameter int unsigned MAX_DIGITS = fpda_pkg::MAX_DIGITS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire fpda_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output fpda_pkg::out_t      out_data_o
);

  localparam int unsigned VALUE_W = fpda_pkg::VALUE_W;
  localparam int unsigned IP_W    = fpda_pkg::IP_W;
  localparam int unsigned EXP_W   = fpda_pkg::EXP_W;
  localparam int unsigned DIG_W   = fpda_pkg::DIG_W;
  localparam int unsigned CNT_W   = $clog2(MAX_DIGITS + 1);
  localparam int unsigned CMP_W   = (IP_W + FRAC_BITS > VALUE_W) ? IP_W + FRAC_BITS : VALUE_W;
  localparam logic [CMP_W-1:0] MAG_LIMIT = CMP_W'(fpda_pkg::RANGE_LIMIT) << FRAC_BITS;
  localparam logic [fpda_pkg::PREC_W-1:0] PREC_LIMIT = fpda_pkg::PREC_W'(MAX_DIGITS);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SPACE = 4'd2;
  localparam logic [3:0] S_MINUS = 4'd3;
  localparam logic [3:0] S_ISUB  = 4'd4;
  localparam logic [3:0] S_COLON = 4'd5;
  localparam logic [3:0] S_PAD   = 4'd6;
  localparam logic [3:0] S_POINT = 4'd7;
  localparam logic [3:0] S_FRAC  = 4'd8;

  logic [3:0]                   state_q, state_d;
  logic [VALUE_W-1:0]           val_q, val_d;
  logic [fpda_pkg::PREC_W-1:0]  prec_q, prec_d;
  logic                         neg_q, neg_d;
  logic                         bad_q, bad_d;
  logic [IP_W-1:0]              ip_q, ip_d;
  logic [FRAC_BITS-1:0]         fr_q, fr_d;
  logic [EXP_W-1:0]             e_q, e_d;
  logic [DIG_W-1:0]             dig_q, dig_d;
  logic [CNT_W-1:0]             left_q, left_d;

  logic                         out_valid_q;
  fpda_pkg::out_t               out_q;
  logic                         out_free;
  logic                         emit_en;
  fpda_pkg::out_t               emit_data;

  logic [VALUE_W-1:0]           mag;
  logic [IP_W-1:0]              ip_chk;
  logic [EXP_W-1:0]             e_chk;

  logic                         unit_ge;
  logic [IP_W-1:0]              unit_ip_diff;
  logic [DIG_W-1:0]             unit_fdig;
  logic [FRAC_BITS-1:0]         unit_fr_next;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  // Magnitude, integer part and its highest decimal place for the check cycle
  assign mag    = val_q[VALUE_W-1] ? (~val_q + VALUE_W'(1)) : val_q;
  assign ip_chk = IP_W'(mag >> FRAC_BITS);

  always_comb begin
    priority if (ip_chk >= fpda_pkg::pow10(3'd4)) begin
      e_chk = 3'd4;
    end else if (ip_chk >= fpda_pkg::pow10(3'd3)) begin
      e_chk = 3'd3;
    end else if (ip_chk >= fpda_pkg::pow10(3'd2)) begin
      e_chk = 3'd2;
    end else if (ip_chk >= fpda_pkg::pow10(3'd1)) begin
      e_chk = 3'd1;
    end else begin
      e_chk = 3'd0;
    end
  end

  fpda_digit_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_digit (
    .ip_i      (ip_q),
    .pow_i     (fpda_pkg::pow10(e_q)),
    .fr_i      (fr_q),
    .ge_o      (unit_ge),
    .ip_diff_o (unit_ip_diff),
    .fdig_o    (unit_fdig),
    .fr_next_o (unit_fr_next)
  );

  // Sequencer
  always_comb begin
    state_d   = state_q;
    val_d     = val_q;
    prec_d    = prec_q;
    neg_d     = neg_q;
    bad_d     = bad_q;
    ip_d      = ip_q;
    fr_d      = fr_q;
    e_d       = e_q;
    dig_d     = dig_q;
    left_d    = left_q;
    emit_en   = 1'b0;
    emit_data = '{char_code: fpda_pkg::CH_ZERO, last_of_run: 1'b0, rejected: 1'b0};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d   = in_data_i.value;
          prec_d  = in_data_i.precision;
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        neg_d   = val_q[VALUE_W-1];
        bad_d   = (CMP_W'(mag) > MAG_LIMIT) || (prec_q > PREC_LIMIT);
        ip_d    = ip_chk;
        fr_d    = mag[FRAC_BITS-1:0];
        e_d     = e_chk;
        state_d = S_SPACE;
      end

      S_SPACE: begin
        if (out_free) begin
          emit_en = 1'b1;
          if (bad_q) begin
            emit_data = '{char_code: fpda_pkg::CH_NONE, last_of_run: 1'b1, rejected: 1'b1};
            state_d   = S_IDLE;
          end else begin
            emit_data.char_code = fpda_pkg::CH_SPACE;
            if (neg_q) begin
              state_d = S_MINUS;
            end else if (prec_q == '0) begin
              state_d = S_PAD;
            end else begin
              dig_d   = '0;
              left_d  = CNT_W'(prec_q);
              state_d = S_ISUB;
            end
          end
        end
      end

      S_MINUS: begin
        if (out_free) begin
          emit_en             = 1'b1;
          emit_data.char_code = fpda_pkg::CH_MINUS;
          if (prec_q == '0) begin
            state_d = S_PAD;
          end else begin
            dig_d   = '0;
            left_d  = CNT_W'(prec_q);
            state_d = S_ISUB;
          end
        end
      end

      // Integer digit by repeated subtraction, then emit; a digit of ten gets '?' first
      S_ISUB, S_COLON: begin
        if (state_q == S_ISUB && unit_ge) begin
          ip_d  = unit_ip_diff;
          dig_d = dig_q + DIG_W'(1);
        end else if (out_free) begin
          emit_en = 1'b1;
          if (state_q == S_ISUB && dig_q > DIG_W'(9)) begin
            emit_data.char_code = fpda_pkg::CH_QUERY;
            state_d             = S_COLON;
          end else begin
            emit_data.char_code   = fpda_pkg::CH_ZERO + fpda_pkg::CHAR_W'(dig_q);
            emit_data.last_of_run = (left_q == CNT_W'(1)) && (e_q == '0);
            if (left_q == CNT_W'(1)) begin
              if (e_q == '0) begin
                state_d = S_IDLE;
              end else begin
                e_d     = e_q - EXP_W'(1);
                state_d = S_PAD;
              end
            end else begin
              left_d = left_q - CNT_W'(1);
              if (e_q == '0) begin
                state_d = S_POINT;
              end else begin
                e_d     = e_q - EXP_W'(1);
                dig_d   = '0;
                state_d = S_ISUB;
              end
            end
          end
        end
      end

      // Integer places the digit count did not reach
      S_PAD: begin
        if (out_free) begin
          emit_en               = 1'b1;
          emit_data.last_of_run = (e_q == '0);
          if (e_q == '0) begin
            state_d = S_IDLE;
          end else begin
            e_d = e_q - EXP_W'(1);
          end
        end
      end

      S_POINT: begin
        if (out_free) begin
          emit_en             = 1'b1;
          emit_data.char_code = fpda_pkg::CH_POINT;
          state_d             = S_FRAC;
        end
      end

      // Fraction digit: carry-out of fraction * 10
      S_FRAC: begin
        if (out_free) begin
          emit_en               = 1'b1;
          emit_data.char_code   = fpda_pkg::CH_ZERO + fpda_pkg::CHAR_W'(unit_fdig);
          emit_data.last_of_run = (left_q == CNT_W'(1));
          fr_d                  = unit_fr_next;
          left_d                = left_q - CNT_W'(1);
          if (left_q == CNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit_en) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers and output beat
  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    prec_q <= prec_d;
    neg_q  <= neg_d;
    bad_q  <= bad_d;
    ip_q   <= ip_d;
    fr_q   <= fr_d;
    e_q    <= e_d;
    dig_q  <= dig_d;
    left_q <= left_d;
    if (emit_en) begin
      out_q <= emit_data;
    end
  end

  // A rejected beat is a lone zero byte closing its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.rejected |-> out_data_o.last_of_run
      && (out_data_o.char_code == fpda_pkg::CH_NONE))
    else $error("rejected beat malformed");

  // An accepted item always goes through the check cycle next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_CHECK)
    else $error("accepted item skipped the check");

  // The subtract loop never runs a digit past ten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ISUB) |-> (dig_q <= DIG_W'(10)))
    else $error("integer digit overran");

  // The sequencer only returns to idle on the last byte of a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) && (state_q != S_CHECK) && (state_d == S_IDLE)
      |-> emit_en && emit_data.last_of_run)
    else $error("run ended without a last byte");

endmodule

`default_nettype wire

@@ verif/fixed_point_to_decimal_ascii_tb.sv @@
// Self-checking testbench for the fixed-point to decimal ASCII converter.
module fixed_point_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC_BITS   = fpda_pkg::FRAC_BITS_DEF;
  localparam int unsigned MAX_DIGITS  = fpda_pkg::MAX_DIGITS_DEF;
  localparam int unsigned VALUE_W     = fpda_pkg::VALUE_W;
  localparam int unsigned CHAR_W      = fpda_pkg::CHAR_W;
  localparam int unsigned RANGE_LIMIT = fpda_pkg::RANGE_LIMIT;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 60;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned PRINT_CAP   = 40;

  // Decimal place weights, units to ten-thousands
  localparam int unsigned DEC_PLACE [5] = '{1, 10, 100, 1000, 10000};
  localparam longint unsigned FRAC_MASK = (64'd1 << FRAC_BITS) - 1;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  fpda_pkg::in_t  in_data_i   = '0;
  logic           out_stall_i = 1'b0;
  logic           in_stall_o;
  logic           out_valid_o;
  fpda_pkg::out_t out_data_o;

  fpda_pkg::out_t expected_chars[$];
  int unsigned    error_count   = 0;
  int unsigned    cycle_count   = 0;
  bit             idle_enabled  = 1'b1;
  bit             long_hold_req = 1'b0;

  fixed_point_to_decimal_ascii #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // One line per mismatch, printing capped so a broken block cannot flood the log
  task automatic report_mismatch(input string what, input fpda_pkg::out_t got,
                                 input fpda_pkg::out_t want);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("[%0t] %s: got char %h last %b rej %b, want char %h last %b rej %b",
               $realtime, what, got.char_code, got.last_of_run, got.rejected,
               want.char_code, want.last_of_run, want.rejected);
  endtask

  function automatic void push_char(input logic [CHAR_W-1:0] ch);
    fpda_pkg::out_t beat;
    beat = '{char_code: ch, last_of_run: 1'b0, rejected: 1'b0};
    expected_chars.push_back(beat);
  endfunction

  // Expected byte run for one accepted number
  function automatic void predict_digits(input fpda_pkg::in_t item);
    logic [VALUE_W:0]  mag;
    logic              neg;
    longint unsigned   ip;
    longint unsigned   fr;
    longint unsigned   d;
    int                place;
    fpda_pkg::out_t    beat;
    neg = item.value[VALUE_W-1];
    mag = neg ? ((51'd1 << VALUE_W) - {1'b0, item.value}) : {1'b0, item.value};
    // Out of range or too many digits: one rejected beat
    if (mag > (51'(RANGE_LIMIT) << FRAC_BITS) || item.precision > MAX_DIGITS) begin
      beat = '{char_code: fpda_pkg::CH_NONE, last_of_run: 1'b1, rejected: 1'b1};
      expected_chars.push_back(beat);
      return;
    end
    push_char(fpda_pkg::CH_SPACE);
    if (neg)
      push_char(fpda_pkg::CH_MINUS);
    ip = mag >> FRAC_BITS;
    fr = mag & FRAC_MASK;
    // Highest non-zero integer place, units at the least
    place = 4;
    while (place > 0 && ip < DEC_PLACE[place])
      place--;
    for (int k = 0; k < int'(item.precision); k++) begin
      if (place == -1)
        push_char(fpda_pkg::CH_POINT);
      if (place >= 0) begin
        d  = ip / DEC_PLACE[place];
        ip = ip - d * DEC_PLACE[place];
      end else begin
        fr = fr * 10;
        d  = fr >> FRAC_BITS;
        fr = fr & FRAC_MASK;
      end
      // a ten in the top place comes out as '?' then ':'
      if (d >= 10)
        push_char(fpda_pkg::CH_QUERY);
      push_char(fpda_pkg::CH_ZERO + CHAR_W'(d));
      place--;
    end
    // integer places not reached by the digit count
    while (place >= 0) begin
      push_char(fpda_pkg::CH_ZERO);
      place--;
    end
    beat = expected_chars.pop_back();
    beat.last_of_run = 1'b1;
    expected_chars.push_back(beat);
  endfunction

  function automatic logic signed [VALUE_W-1:0] to_fixed(input int unsigned neg,
                                                         input int unsigned whole,
                                                         input logic [31:0] frac);
    logic [VALUE_W-1:0] m;
    m = (VALUE_W'(whole) << FRAC_BITS) | VALUE_W'(frac);
    return (neg != 0) ? -m : m;
  endfunction

  function automatic fpda_pkg::in_t make_item(input logic signed [VALUE_W-1:0] v,
                                              input int unsigned p);
    fpda_pkg::in_t item;
    item.value     = v;
    item.precision = fpda_pkg::PREC_W'(p);
    return item;
  endfunction

  // Random number: mostly in range, with edges, raw noise and bad digit counts
  function automatic fpda_pkg::in_t random_item();
    int unsigned r;
    int unsigned digits;
    int unsigned whole;
    int unsigned lo;
    logic [63:0] raw;
    logic [31:0] frac;
    r      = $urandom_range(0, 99);
    digits = $urandom_range(0, 5);
    lo     = (digits <= 1) ? 0 : DEC_PLACE[digits-1];
    whole  = (digits == 0) ? 0 : $urandom_range(lo, DEC_PLACE[digits-1] * 10 - 1);
    frac   = $urandom();
    if (r < 65)
      return make_item(to_fixed($urandom_range(0, 1), whole, frac), $urandom_range(0, 15));
    if (r < 75) begin
      case ($urandom_range(0, 2))
        0:       frac = '0;
        1:       frac = 32'd1;
        default: frac = $urandom();
      endcase
      return make_item(to_fixed($urandom_range(0, 1), RANGE_LIMIT, frac),
                       $urandom_range(0, 15));
    end
    if (r < 88) begin
      raw = {$urandom(), $urandom()};
      return make_item(raw[VALUE_W-1:0], $urandom_range(0, 31));
    end
    return make_item(to_fixed($urandom_range(0, 1), whole, frac), $urandom_range(16, 31));
  endfunction

  // Offer one number, with an optional idle burst first, and predict on acceptance
  task automatic send_number(input fpda_pkg::in_t item);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    predict_digits(item);
  endtask

  // Output side: random stall bursts, and a long hold-off on request
  initial begin : output_stall
    int unsigned held;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        held = 0;
        while (held < LONG_HOLD) begin
          @(posedge clk_i);
          held++;
        end
        out_stall_i   <= 1'b0;
        long_hold_req = 1'b0;
      end else if (idle_enabled && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each output beat with the oldest expected byte
  always @(posedge clk_i) begin : char_check
    fpda_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        want = '0;
        report_mismatch("beat with nothing expected", out_data_o, want);
      end else begin
        want = expected_chars.pop_front();
        if (out_data_o.char_code !== want.char_code ||
            out_data_o.last_of_run !== want.last_of_run ||
            out_data_o.rejected !== want.rejected)
          report_mismatch("beat mismatch", out_data_o, want);
      end
    end
  end

  // Field extremes and range edges
  task automatic test_field_extremes();
    send_number(make_item(to_fixed(0, 0, 0), 0));
    send_number(make_item(to_fixed(0, 0, 0), 3));
    send_number(make_item(to_fixed(0, RANGE_LIMIT, 1), 5));
    send_number(make_item(to_fixed(1, RANGE_LIMIT, 1), 5));
    send_number(make_item({1'b1, {(VALUE_W-1){1'b0}}}, 4));
    send_number(make_item({1'b0, {(VALUE_W-1){1'b1}}}, 4));
    send_number(make_item(to_fixed(0, 42, 0), 16));
    send_number(make_item(to_fixed(1, 42, 0), 31));
    send_number(make_item(to_fixed(1, 0, 32'hFFFF_FFFF), 15));
    send_number(make_item(to_fixed(0, 99999, 32'hFFFF_FFFF), 15));
    send_number(make_item(to_fixed(0, 0, 32'h0000_0001), 15));
  endtask

  // Ten digit, zero count, padding and tiny negatives
  task automatic test_special_cases();
    send_number(make_item(to_fixed(0, RANGE_LIMIT, 0), 15));
    send_number(make_item(to_fixed(1, RANGE_LIMIT, 0), 6));
    send_number(make_item(to_fixed(0, RANGE_LIMIT, 0), 0));
    send_number(make_item(to_fixed(0, RANGE_LIMIT, 0), 1));
    send_number(make_item(to_fixed(1, 0, 32'h0000_0001), 2));
    send_number(make_item(to_fixed(0, 12345, 32'hB3F7_CED9), 15));
    send_number(make_item(to_fixed(0, 12345, 0), 2));
    send_number(make_item(to_fixed(1, 9, 32'h8000_0000), 1));
    send_number(make_item(to_fixed(0, 10, 0), 1));
    send_number(make_item(to_fixed(0, 7, 32'h8000_0000), 3));
    send_number(make_item(to_fixed(1, 3, 32'h0000_0001), 15));
  endtask

  // Output held off for a long stretch while numbers keep coming
  task automatic test_output_backpressure();
    long_hold_req = 1'b1;
    repeat (20)
      send_number(make_item(to_fixed($urandom_range(0, 1), $urandom_range(10000, 99999),
                                     $urandom()), 15));
  endtask

  task automatic test_random_numbers(input int unsigned count);
    repeat (count)
      send_number(random_item());
  endtask

  // Back to back, no idling on either side
  task automatic test_random_steady(input int unsigned count);
    idle_enabled = 1'b0;
    repeat (count)
      send_number(random_item());
    in_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_special_cases();
    test_output_backpressure();
    test_random_numbers(160);
    test_random_steady(50);
    while (expected_chars.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
